FILE: sv/htw_pkg.sv
package htw_pkg;

  localparam int Handles = 32;
  localparam int L0Slots = 256;
  localparam int L1Slots = 64;
  localparam int L2Slots = 64;
  localparam int HW = 5;
  localparam int LW = 6;
  localparam int TW = 48;
  localparam int L0W = 8;
  localparam int L1W = 6;
  localparam int L2W = 6;
  localparam logic [LW-1:0] NIL = LW'(Handles);

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t           op;
    logic [HW-1:0] handle;
    logic [TW-1:0] deadline;
  } cmd_t;

  typedef struct packed {
    logic          kind;
    logic [HW-1:0] evicted_handle;
    logic [LW-1:0] evicted_count;
    logic          last;
  } res_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ARM,
    S_TICK_HEAD,
    S_TICK_WAIT,
    S_WALK,
    S_PLACE,
    S_CASC_HEAD,
    S_CASC_WAIT,
    S_DONE
  } st_t;

  typedef enum logic [1:0] {
    LV_0 = 2'd0,
    LV_1 = 2'd1,
    LV_2 = 2'd2
  } lv_t;

endpackage

FILE: sv/htw_ram.sv
module htw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/htw_fifo.sv
module htw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htw_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output htw_pkg::cmd_t dout
);
  htw_pkg::cmd_t q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt  = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (pop && !empty) begin
      rp_nxt  = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push && !full) begin
      q_r[wp_r] <= din;
    end
  end
endmodule

FILE: sv/htw_rfifo.sv
module htw_rfifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htw_pkg::res_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output htw_pkg::res_t dout
);
  htw_pkg::res_t q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt  = ~wp_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (pop && !empty) begin
      rp_nxt  = ~rp_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push && !full) begin
      q_r[wp_r] <= din;
    end
  end
endmodule

FILE: sv/htw_engine.sv
module htw_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  htw_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output htw_pkg::res_t res
);
  localparam int HW  = htw_pkg::HW;
  localparam int LW  = htw_pkg::LW;
  localparam int TW  = htw_pkg::TW;
  localparam int L0W = htw_pkg::L0W;
  localparam int L1W = htw_pkg::L1W;
  localparam int L2W = htw_pkg::L2W;

  htw_pkg::st_t st_r, st_nxt;

  logic [TW-1:0]  time_r, time_nxt;
  logic [L0W-1:0] i0_r, i0_nxt;
  logic [L1W-1:0] i1_r, i1_nxt;
  logic [L2W-1:0] i2_r, i2_nxt;
  logic [LW-1:0]  cur_r, cur_nxt;
  logic [LW-1:0]  nxt_r, nxt_nxt;
  logic [LW-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]  guard_r, guard_nxt;
  logic [HW-1:0]  ph_r, ph_nxt;
  logic           casc_r, casc_nxt;
  htw_pkg::lv_t   clv_r, clv_nxt;
  // clearing pass over the slot heads after reset
  logic [L0W-1:0] init_r, init_nxt;

  logic [htw_pkg::Handles-1:0] inw_r, inw_nxt, reg_r, reg_nxt;

  logic [LW-1:0]  h0_q, h1_q, h2_q, lnk_q;
  logic [TW-1:0]  dl_q;
  logic           h0_we, h1_we, h2_we, lnk_we, dl_we;
  logic [L0W-1:0] h0_wa, h0_ra;
  logic [L1W-1:0] h1_wa, h1_ra;
  logic [L2W-1:0] h2_wa, h2_ra;
  logic [LW-1:0]  hd_wd;
  logic [HW-1:0]  lnk_wa, lnk_ra, dl_wa, dl_ra;
  logic [LW-1:0]  lnk_wd;
  logic [TW-1:0]  dl_wd;

  htw_ram #(.Width(LW), .Depth(htw_pkg::L0Slots)) u_h0 (
    .clk, .we(h0_we), .waddr(h0_wa), .wdata(hd_wd), .raddr(h0_ra), .rdata(h0_q));
  htw_ram #(.Width(LW), .Depth(htw_pkg::L1Slots)) u_h1 (
    .clk, .we(h1_we), .waddr(h1_wa), .wdata(hd_wd), .raddr(h1_ra), .rdata(h1_q));
  htw_ram #(.Width(LW), .Depth(htw_pkg::L2Slots)) u_h2 (
    .clk, .we(h2_we), .waddr(h2_wa), .wdata(hd_wd), .raddr(h2_ra), .rdata(h2_q));
  htw_ram #(.Width(LW), .Depth(htw_pkg::Handles)) u_lnk (
    .clk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_q));
  htw_ram #(.Width(TW), .Depth(htw_pkg::Handles)) u_dl (
    .clk, .we(dl_we), .waddr(dl_wa), .wdata(dl_wd), .raddr(dl_ra), .rdata(dl_q));

  // placement: delta from time, level and slot chosen by its upper bits
  logic [TW-1:0]  pdl, delta;
  logic [L0W-1:0] ps0;
  logic [L1W-1:0] ps1;
  logic [L2W-1:0] ps2, q2;
  htw_pkg::lv_t   plv;
  logic [LW-1:0]  head_q;

  always_comb begin
    pdl   = (st_r == htw_pkg::S_IDLE || st_r == htw_pkg::S_ARM) ? cmd.deadline : dl_q;
    delta = (pdl > time_r) ? pdl - time_r : '0;
    ps0   = i0_r + delta[L0W-1:0];
    ps1   = i1_r + delta[L0W+L1W-1:L0W];
    q2    = (delta[TW-1:L0W+L1W+L2W] != '0) ? '1 : delta[L0W+L1W+L2W-1:L0W+L1W];
    ps2   = i2_r + q2;
    if (delta[TW-1:L0W] == '0) begin
      plv = htw_pkg::LV_0;
    end else if (delta[TW-1:L0W+L1W] == '0) begin
      plv = htw_pkg::LV_1;
    end else begin
      plv = htw_pkg::LV_2;
    end
    case (clv_r)
      htw_pkg::LV_0: head_q = h0_q;
      htw_pkg::LV_1: head_q = h1_q;
      default:       head_q = h2_q;
    endcase
  end

  logic [LW-1:0] plh;
  always_comb begin
    case (plv)
      htw_pkg::LV_0: plh = h0_q;
      htw_pkg::LV_1: plh = h1_q;
      default:       plh = h2_q;
    endcase
  end

  always_comb begin
    st_nxt = st_r; time_nxt = time_r; i0_nxt = i0_r; i1_nxt = i1_r; i2_nxt = i2_r;
    cur_nxt = cur_r; nxt_nxt = nxt_r; cnt_nxt = cnt_r; guard_nxt = guard_r;
    ph_nxt = ph_r; casc_nxt = casc_r; clv_nxt = clv_r; init_nxt = init_r;
    inw_nxt = inw_r; reg_nxt = reg_r;
    cmd_pop = 1'b0; res_push = 1'b0; res = '0;
    h0_we = 1'b0; h1_we = 1'b0; h2_we = 1'b0; lnk_we = 1'b0; dl_we = 1'b0;
    h0_wa = ps0; h1_wa = ps1; h2_wa = ps2; hd_wd = '0;
    h0_ra = ps0; h1_ra = ps1; h2_ra = ps2;
    lnk_wa = ph_r; lnk_wd = plh; lnk_ra = cur_r[HW-1:0];
    dl_wa = cmd.handle; dl_wd = cmd.deadline; dl_ra = cur_r[HW-1:0];
    case (st_r)
      htw_pkg::S_INIT: begin
        // mark every slot of all three levels empty
        h0_we = 1'b1; h1_we = 1'b1; h2_we = 1'b1;
        h0_wa = init_r; h1_wa = init_r[L1W-1:0]; h2_wa = init_r[L2W-1:0];
        hd_wd = htw_pkg::NIL;
        init_nxt = init_r + 1'b1;
        if (init_r == '1) begin
          st_nxt = htw_pkg::S_IDLE;
        end
      end
      htw_pkg::S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            htw_pkg::OP_ARM: begin
              dl_we = 1'b1;
              reg_nxt[cmd.handle] = 1'b1;
              if (!inw_r[cmd.handle]) begin
                inw_nxt[cmd.handle] = 1'b1;
                ph_nxt = cmd.handle;
                st_nxt = htw_pkg::S_ARM;
              end else begin
                cmd_pop = 1'b1;
              end
            end
            htw_pkg::OP_REMOVE: begin
              reg_nxt[cmd.handle] = 1'b0;
              cmd_pop = 1'b1;
            end
            htw_pkg::OP_TICK: begin
              time_nxt = time_r + 1'b1;
              cnt_nxt = '0;
              casc_nxt = 1'b0;
              clv_nxt = htw_pkg::LV_0;
              h0_ra = i0_r;
              st_nxt = htw_pkg::S_TICK_HEAD;
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      htw_pkg::S_ARM: begin
        // heads were read at the placement slot last cycle: link and push
        lnk_we = 1'b1;
        hd_wd = {1'b0, ph_r};
        case (plv)
          htw_pkg::LV_0: h0_we = 1'b1;
          htw_pkg::LV_1: h1_we = 1'b1;
          default:       h2_we = 1'b1;
        endcase
        cmd_pop = 1'b1;
        st_nxt = htw_pkg::S_IDLE;
      end
      htw_pkg::S_TICK_HEAD, htw_pkg::S_CASC_HEAD: begin
        // take the slot list and clear its head
        cur_nxt = head_q;
        guard_nxt = '0;
        hd_wd = htw_pkg::NIL;
        case (clv_r)
          htw_pkg::LV_0: begin h0_we = 1'b1; h0_wa = i0_r; end
          htw_pkg::LV_1: begin h1_we = 1'b1; h1_wa = i1_r; end
          default:       begin h2_we = 1'b1; h2_wa = i2_r; end
        endcase
        st_nxt = htw_pkg::S_WALK;
      end
      htw_pkg::S_WALK: begin
        if (cur_r >= htw_pkg::NIL || guard_r >= htw_pkg::NIL) begin
          if (!casc_r) begin
            i0_nxt = i0_r + 1'b1;
            if (i0_nxt == '0) begin
              casc_nxt = 1'b1; clv_nxt = htw_pkg::LV_1; h1_ra = i1_r;
              st_nxt = htw_pkg::S_CASC_HEAD;
            end else begin
              st_nxt = htw_pkg::S_DONE;
            end
          end else if (clv_r == htw_pkg::LV_1) begin
            i1_nxt = i1_r + 1'b1;
            if (i1_nxt == '0) begin
              clv_nxt = htw_pkg::LV_2; h2_ra = i2_r;
              st_nxt = htw_pkg::S_CASC_HEAD;
            end else begin
              st_nxt = htw_pkg::S_DONE;
            end
          end else begin
            i2_nxt = i2_r + 1'b1;
            st_nxt = htw_pkg::S_DONE;
          end
        end else begin
          st_nxt = htw_pkg::S_TICK_WAIT;
        end
      end
      htw_pkg::S_TICK_WAIT: begin
        // link and deadline of the current entry now valid
        nxt_nxt = lnk_q;
        guard_nxt = guard_r + 1'b1;
        ph_nxt = cur_r[HW-1:0];
        if (casc_r) begin
          h0_ra = ps0; h1_ra = ps1; h2_ra = ps2;
          st_nxt = htw_pkg::S_PLACE;
        end else if (!reg_r[cur_r[HW-1:0]]) begin
          inw_nxt[cur_r[HW-1:0]] = 1'b0;
          cur_nxt = lnk_q;
          st_nxt = htw_pkg::S_WALK;
        end else if (dl_q > time_r) begin
          st_nxt = htw_pkg::S_PLACE;
        end else if (!res_full) begin
          reg_nxt[cur_r[HW-1:0]] = 1'b0;
          inw_nxt[cur_r[HW-1:0]] = 1'b0;
          res_push = 1'b1;
          res.evicted_handle = cur_r[HW-1:0];
          cnt_nxt = cnt_r + 1'b1;
          cur_nxt = lnk_q;
          st_nxt = htw_pkg::S_WALK;
        end else begin
          guard_nxt = guard_r;
        end
      end
      htw_pkg::S_PLACE: begin
        lnk_we = 1'b1;
        hd_wd = {1'b0, ph_r};
        case (plv)
          htw_pkg::LV_0: h0_we = 1'b1;
          htw_pkg::LV_1: h1_we = 1'b1;
          default:       h2_we = 1'b1;
        endcase
        cur_nxt = nxt_r;
        st_nxt = htw_pkg::S_WALK;
      end
      htw_pkg::S_DONE: begin
        if (!res_full) begin
          res_push = 1'b1;
          res.kind = 1'b1;
          res.evicted_count = cnt_r;
          res.last = 1'b1;
          cmd_pop = 1'b1;
          st_nxt = htw_pkg::S_IDLE;
        end
      end
      default: st_nxt = htw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= htw_pkg::S_INIT;
      init_r <= '0;
      time_r <= '0; i0_r <= '0; i1_r <= '0; i2_r <= '0;
      inw_r <= '0; reg_r <= '0;
      casc_r <= 1'b0; clv_r <= htw_pkg::LV_0; cnt_r <= '0; guard_r <= '0;
    end else begin
      st_r <= st_nxt;
      init_r <= init_nxt;
      time_r <= time_nxt; i0_r <= i0_nxt; i1_r <= i1_nxt; i2_r <= i2_nxt;
      inw_r <= inw_nxt; reg_r <= reg_nxt;
      casc_r <= casc_nxt; clv_r <= clv_nxt; cnt_r <= cnt_nxt; guard_r <= guard_nxt;
    end
    cur_r <= cur_nxt; nxt_r <= nxt_nxt; ph_r <= ph_nxt;
  end
endmodule

FILE: sv/hierarchical_timer_wheel_unit.sv
// Three-level timing wheel over 32 handles (256/64/64 slots). Requests enter a
// two-deep queue; the back end serves one request at a time. After reset the
// back end marks every slot empty while requests wait in the queue. Arm only
// updates the deadline of a handle already in the wheel and otherwise links it
// into its slot; a tick walks the drained slot and, when a lower level wraps,
// the cascaded slots, through registered reads of the slot-head and link
// memories. Each eviction is reported as one result, then one done result
// carrying the count with last set; results wait in a two-deep queue, so a
// slow consumer stalls the walk.
module hierarchical_timer_wheel_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_op,
  input  logic [4:0]  in_handle,
  input  logic [47:0] in_deadline,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [4:0]  out_evicted_handle,
  output logic [5:0]  out_evicted_count,
  output logic        out_last
);
  htw_pkg::cmd_t cin, cq;
  htw_pkg::res_t rq, rout;
  logic cq_empty, cq_pop, rq_push, rq_full;

  assign cin.op       = htw_pkg::op_t'(in_op);
  assign cin.handle   = in_handle;
  assign cin.deadline = in_deadline;

  // front: accept and hold requests
  htw_fifo u_cmdq (
    .clk, .rst_n, .push, .din(cin), .full,
    .pop(cq_pop), .empty(cq_empty), .dout(cq));

  // back: walk and update the wheel
  htw_engine u_eng (
    .clk, .rst_n, .cmd_empty(cq_empty), .cmd(cq), .cmd_pop(cq_pop),
    .res_full(rq_full), .res_push(rq_push), .res(rq));

  htw_rfifo u_resq (
    .clk, .rst_n, .push(rq_push), .din(rq), .full(rq_full),
    .pop, .empty, .dout(rout));

  assign out_kind           = rout.kind;
  assign out_evicted_handle = rout.evicted_handle;
  assign out_evicted_count  = rout.evicted_count;
  assign out_last           = rout.last;

  // a done result always carries last, an eviction never does
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_kind == out_last)) else $error("last mismatch");
  // the engine only takes a request when one waits
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty) else $error("pop of empty request queue");
  // results never enter a full queue
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> !rq_full) else $error("push into full result queue");
endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // Directed row: one request, plus a typed tick count where it is obvious.
  typedef struct packed {
    htw_pkg::op_t           op;
    logic [htw_pkg::HW-1:0] handle;
    logic [htw_pkg::TW-1:0] deadline;
    bit                     known;
    logic [htw_pkg::LW-1:0] known_count;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [1:0]             in_op = htw_pkg::OP_NONE;
  logic [htw_pkg::HW-1:0] in_handle = '0;
  logic [htw_pkg::TW-1:0] in_deadline = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   out_kind;
  logic [htw_pkg::HW-1:0] out_evicted_handle;
  logic [htw_pkg::LW-1:0] out_evicted_count;
  logic                   out_last;

  hierarchical_timer_wheel_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_op              (in_op),
    .in_handle          (in_handle),
    .in_deadline        (in_deadline),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_evicted_handle (out_evicted_handle),
    .out_evicted_count  (out_evicted_count),
    .out_last           (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the wheel.
  logic [htw_pkg::TW-1:0]  now_ms;
  logic [htw_pkg::L0W-1:0] slot0_ptr;
  logic [htw_pkg::L1W-1:0] slot1_ptr;
  logic [htw_pkg::L2W-1:0] slot2_ptr;
  logic [htw_pkg::LW-1:0]  ring0 [htw_pkg::L0Slots];
  logic [htw_pkg::LW-1:0]  ring1 [htw_pkg::L1Slots];
  logic [htw_pkg::LW-1:0]  ring2 [htw_pkg::L2Slots];
  logic [htw_pkg::LW-1:0]  chain [htw_pkg::Handles];
  logic [htw_pkg::TW-1:0]  due_ms [htw_pkg::Handles];
  bit                      linked [htw_pkg::Handles];
  bit                      armed [htw_pkg::Handles];

  htw_pkg::res_t pending_reports[$];
  int   errors = 0;
  int   burst_left = 0;

  // Link a handle into the slot that its distance from now selects.
  function automatic void slot_in(input logic [htw_pkg::HW-1:0] h);
    logic [htw_pkg::TW-1:0]  span;
    logic [htw_pkg::TW-1:0]  q;
    logic [htw_pkg::L0W-1:0] s0;
    logic [htw_pkg::L1W-1:0] s;
    span = (due_ms[h] > now_ms) ? due_ms[h] - now_ms : '0;
    if (span < htw_pkg::L0Slots) begin
      s0 = slot0_ptr + span[htw_pkg::L0W-1:0];
      chain[h] = ring0[s0];
      ring0[s0] = htw_pkg::LW'(h);
    end else if (span < htw_pkg::L0Slots * htw_pkg::L1Slots) begin
      s = slot1_ptr + span[13:8];
      chain[h] = ring1[s];
      ring1[s] = htw_pkg::LW'(h);
    end else begin
      q = span >> 14;
      if (q >= htw_pkg::L2Slots) q = htw_pkg::TW'(htw_pkg::L2Slots - 1);
      s = slot2_ptr + q[htw_pkg::L2W-1:0];
      chain[h] = ring2[s];
      ring2[s] = htw_pkg::LW'(h);
    end
  endfunction

  // Empty the current slot of level 1 or 2 and place every entry again.
  function automatic void cascade_down(input htw_pkg::lv_t lv);
    logic [htw_pkg::LW-1:0] cur;
    logic [htw_pkg::LW-1:0] nxt;
    int guard;
    guard = 0;
    if (lv == htw_pkg::LV_1) begin
      cur = ring1[slot1_ptr];
      ring1[slot1_ptr] = htw_pkg::NIL;
    end else begin
      cur = ring2[slot2_ptr];
      ring2[slot2_ptr] = htw_pkg::NIL;
    end
    while (cur < htw_pkg::Handles && guard < htw_pkg::Handles) begin
      nxt = chain[cur[htw_pkg::HW-1:0]];
      slot_in(cur[htw_pkg::HW-1:0]);
      cur = nxt;
      guard++;
    end
  endfunction

  // Apply one accepted request to the shadow wheel; queue its reports.
  function automatic void apply_request(input htw_pkg::op_t op,
                                        input logic [htw_pkg::HW-1:0] h,
                                        input logic [htw_pkg::TW-1:0] dl);
    logic [htw_pkg::LW-1:0] cur;
    logic [htw_pkg::LW-1:0] nxt;
    int   n;
    int   guard;
    htw_pkg::res_t r;
    n = 0;
    guard = 0;
    case (op)
      htw_pkg::OP_ARM: begin
        due_ms[h] = dl;
        armed[h] = 1'b1;
        if (!linked[h]) begin
          linked[h] = 1'b1;
          slot_in(h);
        end
      end
      htw_pkg::OP_REMOVE: armed[h] = 1'b0;
      htw_pkg::OP_TICK: begin
        now_ms = now_ms + 1'b1;
        cur = ring0[slot0_ptr];
        ring0[slot0_ptr] = htw_pkg::NIL;
        while (cur < htw_pkg::Handles && guard < htw_pkg::Handles) begin
          nxt = chain[cur[htw_pkg::HW-1:0]];
          if (!armed[cur[htw_pkg::HW-1:0]]) begin
            linked[cur[htw_pkg::HW-1:0]] = 1'b0;
          end else if (due_ms[cur[htw_pkg::HW-1:0]] > now_ms) begin
            slot_in(cur[htw_pkg::HW-1:0]);
          end else begin
            armed[cur[htw_pkg::HW-1:0]] = 1'b0;
            linked[cur[htw_pkg::HW-1:0]] = 1'b0;
            r = '{kind: 1'b0, evicted_handle: cur[htw_pkg::HW-1:0],
                  evicted_count: '0, last: 1'b0};
            pending_reports.push_back(r);
            n++;
          end
          cur = nxt;
          guard++;
        end
        slot0_ptr = slot0_ptr + 1'b1;
        if (slot0_ptr == 0) begin
          cascade_down(htw_pkg::LV_1);
          slot1_ptr = slot1_ptr + 1'b1;
          if (slot1_ptr == 0) begin
            cascade_down(htw_pkg::LV_2);
            slot2_ptr = slot2_ptr + 1'b1;
          end
        end
        r = '{kind: 1'b1, evicted_handle: '0, evicted_count: htw_pkg::LW'(n),
              last: 1'b1};
        pending_reports.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Present one request and hold it until the block takes it; bursts and gaps
  // come from the sender's own counter.
  task automatic send_request(input htw_pkg::op_t op,
                              input logic [htw_pkg::HW-1:0] h,
                              input logic [htw_pkg::TW-1:0] dl);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 10);
    end
    burst_left--;
    push        <= 1'b1;
    in_op       <= op;
    in_handle   <= h;
    in_deadline <= dl;
    do @(posedge clk); while (full);
    apply_request(op, h, dl);
  endtask

  // Receiver: switch between free flow, coin-flip and sparse pops.
  int       mode_left = 0;
  int       stall_mode = 0;
  always @(posedge clk) begin : receiver
    htw_pkg::res_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result kind=%0d handle=%0d count=%0d last=%0d",
                   $time, out_kind, out_evicted_handle, out_evicted_count, out_last);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind expected %0d got %0d", $time, want.kind, out_kind);
            errors++;
          end
          if (out_evicted_handle !== want.evicted_handle) begin
            $display("%0t: evicted_handle expected %0d got %0d", $time,
                     want.evicted_handle, out_evicted_handle);
            errors++;
          end
          if (out_evicted_count !== want.evicted_count) begin
            $display("%0t: evicted_count expected %0d got %0d", $time,
                     want.evicted_count, out_evicted_count);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, out_last);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Directed requests: empty tick, ignored op, past deadline, saturation,
  // later and earlier re-arm, remove of armed and unarmed handles.
  script_row_t script [14] = '{
    '{htw_pkg::OP_TICK,   5'd0,  48'd0,               1'b1, 6'd0},
    '{htw_pkg::OP_NONE,   5'd31, 48'hFFFF_FFFF_FFFF,  1'b0, 6'd0},
    '{htw_pkg::OP_ARM,    5'd0,  48'd0,               1'b0, 6'd0},
    '{htw_pkg::OP_TICK,   5'd0,  48'd0,               1'b1, 6'd1},
    '{htw_pkg::OP_ARM,    5'd31, 48'hFFFF_FFFF_FFFF,  1'b0, 6'd0},
    '{htw_pkg::OP_ARM,    5'd5,  48'd3,               1'b0, 6'd0},
    '{htw_pkg::OP_ARM,    5'd5,  48'd400,             1'b0, 6'd0},
    '{htw_pkg::OP_ARM,    5'd6,  48'd4,               1'b0, 6'd0},
    '{htw_pkg::OP_REMOVE, 5'd6,  48'd0,               1'b0, 6'd0},
    '{htw_pkg::OP_REMOVE, 5'd7,  48'hAAAA_5555_AAAA,  1'b0, 6'd0},
    '{htw_pkg::OP_ARM,    5'd8,  48'd10,              1'b0, 6'd0},
    '{htw_pkg::OP_ARM,    5'd8,  48'd3,               1'b0, 6'd0},
    '{htw_pkg::OP_ARM,    5'd9,  48'd300,             1'b0, 6'd0},
    '{htw_pkg::OP_TICK,   5'd0,  48'd0,               1'b0, 6'd0}
  };

  initial begin : stimulus
    htw_pkg::op_t           op;
    logic [htw_pkg::HW-1:0] h;
    logic [htw_pkg::TW-1:0] dl;
    int                     pick;
    now_ms = '0;
    slot0_ptr = '0;
    slot1_ptr = '0;
    slot2_ptr = '0;
    foreach (ring0[i]) ring0[i] = htw_pkg::NIL;
    foreach (ring1[i]) ring1[i] = htw_pkg::NIL;
    foreach (ring2[i]) ring2[i] = htw_pkg::NIL;
    foreach (chain[i]) begin
      chain[i] = '0;
      due_ms[i] = '0;
      linked[i] = 1'b0;
      armed[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_request(script[i].op, script[i].handle, script[i].deadline);
      // Hold the typed count in place of the computed one.
      if (script[i].known)
        pending_reports[pending_reports.size() - 1].evicted_count = script[i].known_count;
    end
    // Drain the directed arms at level 0.
    repeat (12) send_request(htw_pkg::OP_TICK, '0, '0);

    for (int k = 0; k < 480; k++) begin
      if (k == 240) begin
        // Hold off until every report is back.
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      h = htw_pkg::HW'($urandom_range(0, htw_pkg::Handles - 1));
      dl = htw_pkg::TW'({$urandom, $urandom});
      if (pick < 58) begin
        op = htw_pkg::OP_TICK;
      end else if (pick < 88) begin
        op = htw_pkg::OP_ARM;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: dl = now_ms + $urandom_range(0, 30);
          6:                dl = now_ms + $urandom_range(200, 3000);
          7:                ;
          8:                dl = now_ms - $urandom_range(0, 20);
          default:          dl = now_ms + $urandom_range(16384, 100000);
        endcase
      end else if (pick < 98) begin
        op = htw_pkg::OP_REMOVE;
      end else begin
        op = htw_pkg::OP_NONE;
      end
      send_request(op, h, dl);
    end
    push <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
